[design/lidar_sample_sector_tracker_top_macros.svh]
// assertion macros shared by the tracker modules
`ifndef LIDAR_SAMPLE_SECTOR_TRACKER_TOP_MACROS_SVH
`define LIDAR_SAMPLE_SECTOR_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define LSST_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lsst_pkg.sv]
package lsst_pkg;

	localparam int unsigned StoreDepth = 82;
	localparam int unsigned AddrW = 7;
	localparam int unsigned AngleW = 9;
	localparam int unsigned DistW = 14;
	localparam int unsigned MinW = 15;
	localparam int unsigned UsedW = 2 + AngleW + DistW + 4 * MinW;
	localparam int unsigned OutW = ((UsedW + 7) / 8) * 8;
	localparam int unsigned PadW = OutW - UsedW;

	localparam logic [MinW-1:0] StoreReset = 15'd32639;
	localparam logic [MinW-1:0] MinInit = '1;

	localparam logic [AddrW-1:0] LeftBase = 7'd0;
	localparam logic [AddrW-1:0] RightBase = 7'd20;
	localparam logic [AddrW-1:0] RearBase = 7'd40;
	localparam logic [AddrW-1:0] FrontBase = 7'd61;
	localparam logic [AddrW-1:0] LastAddr = 7'd81;

	localparam logic [AngleW-1:0] AngLeftLo = 9'd330;
	localparam logic [AngleW-1:0] AngLeftHi = 9'd349;
	localparam logic [AngleW-1:0] AngRightLo = 9'd11;
	localparam logic [AngleW-1:0] AngRightHi = 9'd30;
	localparam logic [AngleW-1:0] AngRearLo = 9'd170;
	localparam logic [AngleW-1:0] AngRearHi = 9'd190;
	localparam logic [AngleW-1:0] AngFrontLo = 9'd350;
	localparam logic [AngleW-1:0] AngFrontHi = 9'd359;
	localparam logic [AngleW-1:0] AngFrontWrap = 9'd10;

	localparam logic [2:0] LastBytePos = 3'd4;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_MIN = 1'b1;

	typedef struct packed {
		logic byte_en;
		logic scan_start;
		logic scan_en;
		logic load_min;
	} lsst_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} lsst_sts_t;

endpackage

[design/lsst_ctrl.sv]
`include "lidar_sample_sector_tracker_top_macros.svh"

module lsst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tuser,
	output logic               s_tready,
	input  lsst_pkg::lsst_sts_t sts,
	output lsst_pkg::lsst_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_REPORT
	} state_t;

	state_t st_q;
	logic   take;

	assign s_tready = (st_q == ST_IDLE) && !sts.out_busy;
	assign take = s_tvalid && s_tready;

	always_comb begin
		cmd.byte_en = take && (s_tuser == lsst_pkg::CMD_BYTE);
		cmd.scan_start = take && (s_tuser == lsst_pkg::CMD_EVAL);
		cmd.scan_en = (st_q == ST_SCAN);
		cmd.load_min = (st_q == ST_REPORT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (cmd.scan_start) st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) st_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					st_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (!sts.out_busy) st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LSST_NEXT(a_start_scan, cmd.scan_start, st_q == ST_SCAN, "evaluate did not start scan")
	`LSST_NEXT(a_scan_exit, (st_q == ST_SCAN) && sts.scan_last, st_q == ST_FLUSH, "scan overran")
	`LSST_NEXT(a_report_done, cmd.load_min, st_q == ST_IDLE, "report did not return to idle")

endmodule

[design/lsst_dp.sv]
`include "lidar_sample_sector_tracker_top_macros.svh"

module lsst_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [7:0]                       s_tdata,
	input  lsst_pkg::lsst_cmd_t              cmd,
	output lsst_pkg::lsst_sts_t              sts,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [lsst_pkg::OutW-1:0]        m_tdata,
	output logic                             m_tuser
);

	logic [2:0]                       pos_q;
	logic [7:0]                       held_q [4];
	logic [lsst_pkg::DistW-1:0]       mem [lsst_pkg::StoreDepth];
	logic [lsst_pkg::StoreDepth-1:0]  vld_q;

	logic [lsst_pkg::AddrW-1:0]       scan_addr_q;
	logic                             act_s1;
	logic [lsst_pkg::DistW-1:0]       rd_s1;
	logic                             rdv_s1;
	logic [lsst_pkg::AddrW-1:0]       addr_s1;
	logic [lsst_pkg::MinW-1:0]        rd_val;

	logic [lsst_pkg::MinW-1:0]        min_left_q;
	logic [lsst_pkg::MinW-1:0]        min_right_q;
	logic [lsst_pkg::MinW-1:0]        min_rear_q;
	logic [lsst_pkg::MinW-1:0]        min_front_q;

	logic                             m_tvalid_q;
	logic [lsst_pkg::OutW-1:0]        m_tdata_q;
	logic                             m_tuser_q;

	logic                             last_byte;
	logic                             frame_ok;
	logic [lsst_pkg::AngleW-1:0]      angle;
	logic [lsst_pkg::DistW-1:0]       distance;
	logic                             in_sector;
	logic [lsst_pkg::AngleW-1:0]      slot_w;
	logic [lsst_pkg::AddrW-1:0]       slot;
	logic                             stored;
	logic [lsst_pkg::AngleW-1:0]      angle_o;
	logic [lsst_pkg::DistW-1:0]       dist_o;

	// sample decode
	assign last_byte = (pos_q == lsst_pkg::LastBytePos);
	assign frame_ok = (held_q[0][0] != held_q[0][1]) && held_q[1][0];
	assign angle = {held_q[2], held_q[1][7]};
	assign distance = {s_tdata, held_q[3][7:2]};

	always_comb begin
		in_sector = 1'b1;
		slot_w = '0;
		if (angle >= lsst_pkg::AngLeftLo && angle <= lsst_pkg::AngLeftHi) begin
			slot_w = angle - lsst_pkg::AngLeftLo + {2'b0, lsst_pkg::LeftBase};
		end else if (angle >= lsst_pkg::AngRightLo && angle <= lsst_pkg::AngRightHi) begin
			slot_w = angle - lsst_pkg::AngRightLo + {2'b0, lsst_pkg::RightBase};
		end else if (angle >= lsst_pkg::AngRearLo && angle <= lsst_pkg::AngRearHi) begin
			slot_w = angle - lsst_pkg::AngRearLo + {2'b0, lsst_pkg::RearBase};
		end else if (angle >= lsst_pkg::AngFrontLo && angle <= lsst_pkg::AngFrontHi) begin
			slot_w = angle - lsst_pkg::AngFrontLo + {2'b0, lsst_pkg::FrontBase};
		end else if (angle <= lsst_pkg::AngFrontWrap) begin
			slot_w = angle + {2'b0, lsst_pkg::FrontBase} + lsst_pkg::AngFrontWrap;
		end else begin
			in_sector = 1'b0;
		end
	end

	assign slot = slot_w[lsst_pkg::AddrW-1:0];
	assign stored = frame_ok && (distance != '0) && in_sector;
	assign angle_o = frame_ok ? angle : '0;
	assign dist_o = frame_ok ? distance : '0;

	// byte assembly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.byte_en) begin
			pos_q <= last_byte ? 3'd0 : pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_en && !last_byte) begin
			held_q[pos_q[1:0]] <= s_tdata;
		end
	end

	// sector store
	always_ff @(posedge clk) begin
		if (cmd.byte_en && last_byte && stored) begin
			mem[slot] <= distance;
		end
		rd_s1 <= mem[scan_addr_q];
		rdv_s1 <= vld_q[scan_addr_q];
		addr_s1 <= scan_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.byte_en && last_byte && stored) begin
			vld_q[slot] <= 1'b1;
		end
	end

	// scan walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= cmd.scan_en;
			if (cmd.scan_start) begin
				scan_addr_q <= '0;
			end else if (cmd.scan_en && scan_addr_q != lsst_pkg::LastAddr) begin
				scan_addr_q <= scan_addr_q + 7'd1;
			end
		end
	end

	assign rd_val = rdv_s1 ? {1'b0, rd_s1} : lsst_pkg::StoreReset;

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			min_left_q <= lsst_pkg::MinInit;
			min_right_q <= lsst_pkg::MinInit;
			min_rear_q <= lsst_pkg::MinInit;
			min_front_q <= lsst_pkg::MinInit;
		end else if (act_s1) begin
			if (addr_s1 < lsst_pkg::RightBase) begin
				if (rd_val < min_left_q) min_left_q <= rd_val;
			end else if (addr_s1 < lsst_pkg::RearBase) begin
				if (rd_val < min_right_q) min_right_q <= rd_val;
			end else if (addr_s1 < lsst_pkg::FrontBase) begin
				if (rd_val < min_rear_q) min_rear_q <= rd_val;
			end else begin
				if (rd_val < min_front_q) min_front_q <= rd_val;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((cmd.byte_en && last_byte) || cmd.load_min) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_en && last_byte) begin
			m_tuser_q <= lsst_pkg::KIND_SAMPLE;
			m_tdata_q <= {{lsst_pkg::PadW{1'b0}}, {(4 * lsst_pkg::MinW){1'b0}},
				stored, dist_o, angle_o, frame_ok};
		end else if (cmd.load_min) begin
			m_tuser_q <= lsst_pkg::KIND_MIN;
			m_tdata_q <= {{lsst_pkg::PadW{1'b0}}, min_front_q, min_rear_q, min_right_q,
				min_left_q, 1'b0, {lsst_pkg::DistW{1'b0}}, {lsst_pkg::AngleW{1'b0}}, 1'b0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	assign sts.scan_last = (scan_addr_q == lsst_pkg::LastAddr);
	assign sts.out_busy = m_tvalid_q && !m_tready;

	`LSST_HOLDS(a_stored_ok, m_tvalid && m_tdata[24], m_tdata[0] && (m_tdata[23:10] != '0), "stored without valid sample")
	`LSST_HOLDS(a_addr_range, 1'b1, scan_addr_q <= lsst_pkg::LastAddr, "scan address out of range")
	`LSST_NEXT(a_min_load, cmd.load_min, m_tvalid && (m_tuser == lsst_pkg::KIND_MIN), "minima report not loaded")

endmodule

[design/lidar_sample_sector_tracker_top.sv]
// byte item: a fifth byte's report is registered in the output register and valid the cycle after the byte is taken
// evaluate item: walks the 82-entry sector store one entry per cycle over a single read port,
// report registered in the report state after the scan and flush states, input held off until then
// throughput: one byte item per cycle outside an evaluate while the output register drains
// reset: byte count cleared, every store entry reads 32639 through per-entry valid bits, no clearing pass
module lidar_sample_sector_tracker_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // rx_byte
	input  logic                         s_tuser,  // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// frame_ok, sample_angle, sample_distance, stored, min_left, min_right, min_rear, min_front
	output logic [lsst_pkg::OutW-1:0]    m_tdata,
	output logic                         m_tuser   // result_kind
);

	lsst_pkg::lsst_cmd_t cmd;
	lsst_pkg::lsst_sts_t sts;

	lsst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
